/* rtl/led_pixel_output_formatter_unit_assert.svh */
// Assertion macros shared by the formatter modules.
`ifndef LED_PIXEL_OUTPUT_FORMATTER_UNIT_ASSERT_SVH
`define LED_PIXEL_OUTPUT_FORMATTER_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define LPOF_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("lpof: invariant violated");

// Check a consequence in the same cycle.
`define LPOF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpof: same-cycle implication violated");

// Check a consequence in the following cycle.
`define LPOF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpof: next-cycle implication violated");

`endif

/* rtl/lpof_pkg.sv */
package lpof_pkg;

   // Queue depth between front and back
   localparam int unsigned LPOF_QUEUE_DEPTH = 2;

   // Register indexes of the configuration port
   localparam logic [3:0] LPOF_REG_CURVE_ENABLE     = 4'd0;
   localparam logic [3:0] LPOF_REG_BRIGHTNESS_LEVEL = 4'd1;
   localparam logic [3:0] LPOF_REG_CHANNEL_ORDER    = 4'd2;
   localparam logic [3:0] LPOF_REG_BYTES_PER_PIXEL  = 4'd3;

   // Reset values of the registers
   localparam logic       LPOF_RST_CURVE_ENABLE     = 1'b0;
   localparam logic [8:0] LPOF_RST_BRIGHTNESS_LEVEL = 9'd256;
   localparam logic [7:0] LPOF_RST_CHANNEL_ORDER    = 8'd33;
   localparam logic [2:0] LPOF_RST_BYTES_PER_PIXEL  = 3'd3;

   // Last byte index of a pixel for 3 and 4 byte strips
   localparam logic [1:0] LPOF_LAST_IDX_RGB  = 2'd2;
   localparam logic [1:0] LPOF_LAST_IDX_RGBW = 2'd3;

   // Divisor of the quadratic curve
   localparam int CURVE_DIV = 254;

   typedef logic [7:0] curve_table_type [256];

   typedef struct packed {
      logic       curve_enable;
      logic [8:0] brightness_level;
      logic [7:0] channel_order;
      logic [2:0] bytes_per_pixel;
   } lpof_cfg_type;

   // One pixel after curve, scaling and reordering
   typedef struct packed {
      logic [3:0][7:0] byte_list;
      logic [1:0]      last_index;
      logic            end_of_strip;
   } lpof_entry_type;

   // Build the curve table at elaboration: 0 stays 0, else 1 + (v-1)^2/254
   function automatic curve_table_type build_curve();
      curve_table_type tab;
      int d;
      tab[0] = 8'd0;
      for (int i = 1; i < 256; i++) begin
         d = i - 1;
         tab[i] = 8'(1 + (d * d) / CURVE_DIV);
      end
      return tab;
   endfunction

   localparam curve_table_type CURVE_TABLE = build_curve();

   // Scale by level/256; level of 256 and above passes the value through
   function automatic logic [7:0] lpof_scale(input logic [7:0] v, input logic [8:0] level);
      logic [15:0] prod;
      prod = v * level[7:0];
      return level[8] ? v : prod[15:8];
   endfunction

endpackage

/* rtl/lpof_front.sv */
module lpof_front (
   input  logic                    clock,
   input  logic                    reset,
   input  lpof_pkg::lpof_cfg_type  cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_red,
   input  logic [7:0]              req_green,
   input  logic [7:0]              req_blue,
   input  logic                    req_end_of_strip,
   output logic                    q_wr_valid,
   input  logic                    q_wr_ready,
   output lpof_pkg::lpof_entry_type q_wr_entry
);
   import lpof_pkg::*;

   logic           valid_ff, valid_in;
   lpof_entry_type entry_ff, entry_in;
   logic [7:0]     raw  [3];
   logic [7:0]     src  [4];
   logic           accept;

   // Take a new pixel whenever the stage is empty or drains this cycle
   assign req_ready  = !valid_ff || q_wr_ready;
   assign accept     = req_valid && req_ready;
   assign q_wr_valid = valid_ff;
   assign q_wr_entry = entry_ff;

   // Apply curve and brightness, then pick bytes by order slot
   always_comb begin
      raw[0] = req_red;
      raw[1] = req_green;
      raw[2] = req_blue;
      for (int c = 0; c < 3; c++) begin
         src[c] = lpof_scale(cfg.curve_enable ? CURVE_TABLE[raw[c]] : raw[c],
                             cfg.brightness_level);
      end
      src[3] = 8'd0;
      for (int k = 0; k < 4; k++) begin
         entry_in.byte_list[k] = src[cfg.channel_order[2*k +: 2]];
      end
      entry_in.last_index   = cfg.bytes_per_pixel[2] ? LPOF_LAST_IDX_RGBW
                                                     : LPOF_LAST_IDX_RGB;
      entry_in.end_of_strip = req_end_of_strip;
   end

   // Hold the pixel until the queue takes it
   assign valid_in = accept ? 1'b1 : (q_wr_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

/* rtl/lpof_queue.sv */
`include "led_pixel_output_formatter_unit_assert.svh"

module lpof_queue #(
   parameter int unsigned DEPTH = lpof_pkg::LPOF_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_valid,
   output logic                     wr_ready,
   input  lpof_pkg::lpof_entry_type wr_entry,
   output logic                     rd_valid,
   input  logic                     rd_ready,
   output lpof_pkg::lpof_entry_type rd_entry
);
   import lpof_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   lpof_entry_type   entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign wr_ready = count_ff != CNT_W'(DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_entry = entries_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the written pixel
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   `LPOF_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `LPOF_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `LPOF_ASSERT_NEXT(a_pop_shrinks, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

/* rtl/lpof_back.sv */
`include "led_pixel_output_formatter_unit_assert.svh"

module lpof_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_rd_valid,
   output logic                     q_rd_ready,
   input  lpof_pkg::lpof_entry_type q_rd_entry,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_pixel_done,
   output logic                     rsp_strip_done
);
   import lpof_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       pixel_done_ff;
   logic       strip_done_ff;
   logic       load, last;

   // Load the output register when it is empty or being taken
   assign load       = q_rd_valid && (!valid_ff || rsp_ready);
   assign last       = idx_ff == q_rd_entry.last_index;
   assign q_rd_ready = load && last;

   assign idx_in   = load ? (last ? 2'd0 : idx_ff + 2'd1) : idx_ff;
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Capture the next byte and its flags
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= q_rd_entry.byte_list[idx_ff];
         pixel_done_ff <= last;
         strip_done_ff <= last && q_rd_entry.end_of_strip;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_pixel_done = pixel_done_ff;
   assign rsp_strip_done = strip_done_ff;

   `LPOF_ASSERT_IMPLIES(a_strip_has_pixel, clock, reset, valid_ff && strip_done_ff, pixel_done_ff)
   `LPOF_ASSERT_IMPLIES(a_pop_on_last, clock, reset, q_rd_valid && q_rd_ready, idx_ff == q_rd_entry.last_index)
   `LPOF_ASSERT_NEXT(a_idx_restart, clock, reset, q_rd_valid && q_rd_ready, idx_ff == 2'd0)

endmodule

/* rtl/led_pixel_output_formatter_unit.sv */
// LED pixel output formatter.
// Input channel (req_*): one RGB pixel per item plus an end-of-strip flag.
// Result channel (rsp_*): one strip byte per item, 3 or 4 per pixel in the
// configured channel order; rsp_pixel_done marks a pixel's last byte and
// rsp_strip_done the last byte of the strip's final pixel.
// Config channel (csr_*): always ready; index 0 curve enable, 1 brightness,
// 2 channel order, 3 bytes per pixel; other indexes are ignored. Write it
// only while no pixel is in flight.
// An accepted pixel is registered in the front stage, then in a queue entry,
// and its first byte then in the output register.
// Throughput: one byte per cycle while rsp_ready stays high, from the
// single output register of the byte emitter. A two-entry queue lets the
// front take new pixels while bytes are still going out.
// Reset: registers return to curve off, brightness 256 (no scaling), order
// G,R,B and 3 bytes per pixel; all queued pixels are dropped.
// Stall: with rsp_ready low the current byte holds; the queue and front
// stage fill, then req_ready drops.
module led_pixel_output_formatter_unit #(
   parameter int unsigned QUEUE_DEPTH = lpof_pkg::LPOF_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic       req_end_of_strip,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_pixel_done,
   output logic       rsp_strip_done,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_index,
   input  logic [8:0] csr_data
);
   import lpof_pkg::*;

   lpof_cfg_type   cfg_ff, cfg_in;
   logic           q_wr_valid, q_wr_ready;
   lpof_entry_type q_wr_entry;
   logic           q_rd_valid, q_rd_ready;
   lpof_entry_type q_rd_entry;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            LPOF_REG_CURVE_ENABLE:     cfg_in.curve_enable     = csr_data[0];
            LPOF_REG_BRIGHTNESS_LEVEL: cfg_in.brightness_level = csr_data;
            LPOF_REG_CHANNEL_ORDER:    cfg_in.channel_order    = csr_data[7:0];
            LPOF_REG_BYTES_PER_PIXEL:  cfg_in.bytes_per_pixel  = csr_data[2:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.curve_enable     <= LPOF_RST_CURVE_ENABLE;
         cfg_ff.brightness_level <= LPOF_RST_BRIGHTNESS_LEVEL;
         cfg_ff.channel_order    <= LPOF_RST_CHANNEL_ORDER;
         cfg_ff.bytes_per_pixel  <= LPOF_RST_BYTES_PER_PIXEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpof_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_end_of_strip (req_end_of_strip),
      .q_wr_valid       (q_wr_valid),
      .q_wr_ready       (q_wr_ready),
      .q_wr_entry       (q_wr_entry)
   );

   lpof_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_wr_valid),
      .wr_ready (q_wr_ready),
      .wr_entry (q_wr_entry),
      .rd_valid (q_rd_valid),
      .rd_ready (q_rd_ready),
      .rd_entry (q_rd_entry)
   );

   lpof_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_rd_valid     (q_rd_valid),
      .q_rd_ready     (q_rd_ready),
      .q_rd_entry     (q_rd_entry),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_pixel_done (rsp_pixel_done),
      .rsp_strip_done (rsp_strip_done)
   );

endmodule
